>>> hdl/command_frame_receiver_defines.svh
// Assertion macros for the command frame receiver.
// Include from inside a module that has clk and rst_n in scope.
`ifndef COMMAND_FRAME_RECEIVER_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cfr_pkg.sv
// Package for the command frame receiver: codes, constants and the CRC-32 byte step.
// No dependencies.
package cfr_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE        = 2'd0,
    ACT_ACK_TIMEOUT = 2'd1,
    ACT_RESET_TIMER = 2'd2,
    ACT_IGNORE      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_K    = 2'd1,
    REPLY_N    = 2'd2
  } reply_t;

  localparam logic CFG_CRC_SEED    = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  localparam logic [7:0]  CMD_G = 8'h47;
  localparam logic [7:0]  CMD_L = 8'h4C;
  localparam logic [7:0]  CMD_K = 8'h4B;
  localparam logic [7:0]  CMD_N = 8'h4E;

  localparam logic [7:0]  DECODE_OFFSET  = 8'd13;
  localparam logic [7:0]  RETRY_MAX      = 8'hFF;
  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_INVERT     = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_SEED_RESET = 32'hFFFFFFFF;
  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd3;

  localparam logic signed [15:0] ASCII_ZERO  = 16'sd48;
  localparam logic signed [15:0] ACQ_MAX_S   = 16'sd999;
  localparam logic [9:0]         ACQ_MAX     = 10'd999;
  localparam int                 FRAME_LAST  = 7;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/command_frame_receiver.sv
// Command frame receiver: decodes 8-byte CRC-protected command frames and retry events.
// Depends on cfr_pkg and command_frame_receiver_defines.svh.
//
// Takes one word per clock while the input is not stalled. A word passes an input
// register and then a result register; the frame state, CRC and retry counter are
// updated from the input register as its word moves on. Words that raise no
// result (frame bytes 0-6, reset-timer and ignore events) still flow at one per clock
// unless the input stalls. The input stalls only while the result register holds an
// untaken result and the input register is full. Configuration writes are always ready.
`include "command_frame_receiver_defines.svh"

module command_frame_receiver (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_rx_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_crc_ok,
  output logic [7:0]            out_command,
  output logic [1:0]            out_reply,
  output logic                  out_go_pulse,
  output logic                  out_load_counter,
  output logic [9:0]            out_acq_time,
  output logic                  out_ack_seen,
  output logic                  out_resend,
  output logic                  out_reset_pulse
);
  import cfr_pkg::*;

  // configuration registers
  logic [31:0] seed_r;
  logic [7:0]  limit_r;

  // input stage
  logic        s1_valid_r;
  action_t     s1_action_r;
  logic [7:0]  s1_byte_r;

  // frame and link state
  logic [2:0]         pos_r,       pos_nxt;
  logic [31:0]        crc_r,       crc_nxt;
  logic [7:0]         cmd_r,       cmd_nxt;
  logic signed [15:0] digit_r,     digit_nxt;
  logic [31:0]        carried_r,   carried_nxt;
  logic [9:0]         acq_r,       acq_nxt;
  logic [7:0]         retry_r,     retry_nxt;
  logic               resetting_r, resetting_nxt;

  // result register
  logic        out_valid_r;
  logic        crc_ok_r, go_r, load_r, ack_r, resend_r, rst_pulse_r;
  logic [7:0]  command_r;
  reply_t      reply_r;
  logic [9:0]  acq_out_r;

  // combinational result
  logic        res_valid_c, crc_ok_c, go_c, load_c, ack_c, resend_c, rst_pulse_c;
  logic [7:0]  command_c;
  reply_t      reply_c;

  logic        adv, in_fire, s1_fire;
  logic [7:0]  dec_byte;
  logic [7:0]  retry_inc;
  logic        limit_hit;
  logic        fail, resend_if_ok;
  logic signed [15:0] digit_sum;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign in_fire   = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && adv;

  assign dec_byte  = s1_byte_r - DECODE_OFFSET;
  assign retry_inc = (retry_r == RETRY_MAX) ? retry_r : retry_r + 8'd1;
  assign limit_hit = retry_inc >= limit_r;
  // digit * 10 by shift-add; the partial sum stays within 16 bits signed
  assign digit_sum = (digit_r <<< 3) + (digit_r <<< 1)
                     + ($signed({8'd0, dec_byte}) - ASCII_ZERO);

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    cmd_nxt       = cmd_r;
    digit_nxt     = digit_r;
    carried_nxt   = carried_r;
    acq_nxt       = acq_r;
    retry_nxt     = retry_r;
    resetting_nxt = resetting_r;
    res_valid_c   = 1'b0;
    crc_ok_c      = 1'b0;
    command_c     = 8'd0;
    reply_c       = REPLY_NONE;
    go_c          = 1'b0;
    load_c        = 1'b0;
    ack_c         = 1'b0;
    resend_c      = 1'b0;
    rst_pulse_c   = 1'b0;
    fail          = 1'b0;
    resend_if_ok  = 1'b0;

    if (s1_fire) begin
      case (s1_action_r)
        ACT_RESET_TIMER: begin
          retry_nxt     = 8'd0;
          resetting_nxt = 1'b0;
        end
        ACT_ACK_TIMEOUT: begin
          res_valid_c  = 1'b1;
          fail         = 1'b1;
          resend_if_ok = 1'b1;
        end
        ACT_BYTE: begin
          pos_nxt = pos_r + 3'd1;
          if (pos_r == 3'd0) begin
            crc_nxt   = crc32_byte(seed_r, dec_byte);
            cmd_nxt   = dec_byte;
            digit_nxt = 16'sd0;
          end else if (pos_r < 3'd4) begin
            crc_nxt   = crc32_byte(crc_r, dec_byte);
            digit_nxt = digit_sum;
          end else begin
            carried_nxt = {carried_r[23:0], dec_byte};
          end

          if (pos_r == 3'(FRAME_LAST)) begin
            res_valid_c = 1'b1;
            command_c   = cmd_r;
            crc_ok_c    = (crc_r ^ CRC_INVERT) == carried_nxt;
            if (!crc_ok_c) begin
              reply_c = REPLY_N;
            end else begin
              case (cmd_r)
                CMD_G: begin
                  go_c    = 1'b1;
                  load_c  = 1'b1;
                  reply_c = REPLY_K;
                end
                CMD_L: begin
                  if (digit_r < 16'sd0) begin
                    acq_nxt = 10'd0;
                  end else if (digit_r > ACQ_MAX_S) begin
                    acq_nxt = ACQ_MAX;
                  end else begin
                    acq_nxt = digit_r[9:0];
                  end
                  load_c  = 1'b1;
                  reply_c = REPLY_K;
                end
                CMD_K: begin
                  retry_nxt = 8'd0;
                  ack_c     = 1'b1;
                end
                CMD_N: begin
                  fail         = 1'b1;
                  resend_if_ok = 1'b1;
                end
                default: begin
                  fail    = 1'b1;
                  reply_c = REPLY_N;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    // failure count; reaching the limit requests a radio reset
    if (fail) begin
      if (limit_hit) begin
        retry_nxt = 8'd0;
        if (!resetting_r) begin
          rst_pulse_c   = 1'b1;
          resetting_nxt = 1'b1;
        end
      end else begin
        retry_nxt = retry_inc;
        resend_c  = resend_if_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= CRC_SEED_RESET;
      limit_r     <= RETRY_LIMIT_RESET;
      s1_valid_r  <= 1'b0;
      pos_r       <= 3'd0;
      crc_r       <= CRC_SEED_RESET;
      cmd_r       <= 8'd0;
      digit_r     <= 16'sd0;
      carried_r   <= 32'd0;
      acq_r       <= 10'd0;
      retry_r     <= 8'd0;
      resetting_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CRC_SEED:    seed_r  <= cfg_data;
          CFG_RETRY_LIMIT: limit_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      cmd_r       <= cmd_nxt;
      digit_r     <= digit_nxt;
      carried_r   <= carried_nxt;
      acq_r       <= acq_nxt;
      retry_r     <= retry_nxt;
      resetting_r <= resetting_nxt;

      if (s1_fire) begin
        out_valid_r <= res_valid_c;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= action_t'(in_action);
      s1_byte_r   <= in_rx_byte;
    end
    if (s1_fire && res_valid_c) begin
      crc_ok_r    <= crc_ok_c;
      command_r   <= command_c;
      reply_r     <= reply_c;
      go_r        <= go_c;
      load_r      <= load_c;
      acq_out_r   <= acq_nxt;
      ack_r       <= ack_c;
      resend_r    <= resend_c;
      rst_pulse_r <= rst_pulse_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_crc_ok       = crc_ok_r;
  assign out_command      = command_r;
  assign out_reply        = reply_r;
  assign out_go_pulse     = go_r;
  assign out_load_counter = load_r;
  assign out_acq_time     = acq_out_r;
  assign out_ack_seen     = ack_r;
  assign out_resend       = resend_r;
  assign out_reset_pulse  = rst_pulse_r;

  `CFR_ASSERT_IMPL(a_stall_needs_word, in_stall, s1_valid_r && out_valid_r, "stall with nothing held")
  `CFR_ASSERT_NEXT(a_reset_sets_flag, s1_fire && rst_pulse_c, resetting_r, "reset pulse without flag set")
  `CFR_ASSERT_IMPL(a_bad_crc_quiet, out_valid_r && !crc_ok_r, !go_r && !load_r && !ack_r, "acted on bad CRC")
  `CFR_ASSERT_IMPL(a_pulse_excl, out_valid_r, !(out_resend && out_reset_pulse), "resend and reset pulse together")

endmodule

>>> dv/testbench.sv
// Self-checking bench for command_frame_receiver: directed table, then random phases.
// Depends on cfr_pkg and the RTL under hdl; carries its own model of frame, CRC and retry logic.
module testbench;
  import cfr_pkg::*;

  typedef struct packed {
    logic       crc_ok;
    logic [7:0] command;
    reply_t     reply;
    logic       go;
    logic       load;
    logic [9:0] acq;
    logic       ack;
    logic       resend;
    logic       rst;
  } frame_result_t;

  typedef struct packed {
    bit            is_frame;
    action_t       act;
    logic [31:0]   body;   // decoded bytes 0-3, byte 0 in the top; raw byte for single words
    bit            bad_crc;
    bit            typed;
    frame_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_CRC_SEED;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_BYTE;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_crc_ok;
  logic [7:0]  out_command;
  logic [1:0]  out_reply;
  logic        out_go_pulse;
  logic        out_load_counter;
  logic [9:0]  out_acq_time;
  logic        out_ack_seen;
  logic        out_resend;
  logic        out_reset_pulse;

  command_frame_receiver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_crc_ok       (out_crc_ok),
    .out_command      (out_command),
    .out_reply        (out_reply),
    .out_go_pulse     (out_go_pulse),
    .out_load_counter (out_load_counter),
    .out_acq_time     (out_acq_time),
    .out_ack_seen     (out_ack_seen),
    .out_resend       (out_resend),
    .out_reset_pulse  (out_reset_pulse)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state and register copies
  logic [31:0] seed_q = CRC_SEED_RESET;
  logic [7:0]  limit_q = RETRY_LIMIT_RESET;
  logic [2:0]  frame_pos = '0;
  logic [31:0] run_crc = CRC_SEED_RESET;
  logic [7:0]  frame_cmd = '0;
  int          digits = 0;
  logic [31:0] carried = '0;
  logic [9:0]  acq = '0;
  logic [7:0]  retries = '0;
  logic        resetting = 1'b0;

  frame_result_t results_due[$];
  int unsigned   mismatches = 0;
  int unsigned   words_sent = 0;
  int unsigned   tx_quiet = 0;
  plan_row_t     plan[9];

  function automatic frame_result_t outcome(logic crc_ok, logic [7:0] command, reply_t reply,
                                            logic go, logic load, logic [9:0] acq_v,
                                            logic ack, logic resend, logic rst);
    frame_result_t r;
    r.crc_ok = crc_ok;  r.command = command;  r.reply = reply;
    r.go = go;          r.load = load;        r.acq = acq_v;
    r.ack = ack;        r.resend = resend;    r.rst = rst;
    return r;
  endfunction

  // Bit-serial form of the reflected CRC-32, LSB of the byte first
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c;
    for (int i = 0; i < 8; i++)
      x = (x >> 1) ^ ((x[0] ^ b[i]) ? CRC_POLY : 32'd0);
    return x;
  endfunction

  function automatic logic [7:0] digit_byte();
    if ($urandom_range(0, 4) != 0)
      return 8'(ASCII_ZERO) + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic tally_failure(output bit limit_hit, output logic pulse);
    if (retries != RETRY_MAX)
      retries++;
    if (retries >= limit_q) begin
      limit_hit = 1'b1;
      retries = '0;
      pulse = !resetting;
      resetting = 1'b1;
    end else begin
      limit_hit = 1'b0;
      pulse = 1'b0;
    end
  endtask

  task automatic predict_word(input action_t a, input logic [7:0] raw,
                              output bit got, output frame_result_t r);
    logic [7:0] d;
    bit         hit;
    logic       p;
    int         t;
    r = '0;
    got = 1'b0;
    case (a)
      ACT_RESET_TIMER: begin
        retries = '0;
        resetting = 1'b0;
      end
      ACT_ACK_TIMEOUT: begin
        tally_failure(hit, p);
        r.resend = !hit;
        r.rst = p;
        got = 1'b1;
      end
      ACT_BYTE: begin
        d = raw - DECODE_OFFSET;
        if (frame_pos == 3'd0) begin
          run_crc = crc_step(seed_q, d);
          frame_cmd = d;
          digits = 0;
        end else if (frame_pos < 3'd4) begin
          run_crc = crc_step(run_crc, d);
          digits = digits * 10 + (int'(d) - int'(ASCII_ZERO));
        end else begin
          carried = {carried[23:0], d};
        end
        if (frame_pos == 3'(FRAME_LAST)) begin
          got = 1'b1;
          r.command = frame_cmd;
          r.crc_ok = ((run_crc ^ CRC_INVERT) == carried);
          if (!r.crc_ok) begin
            r.reply = REPLY_N;
          end else begin
            case (frame_cmd)
              CMD_G: begin
                r.go = 1'b1;
                r.load = 1'b1;
                r.reply = REPLY_K;
              end
              CMD_L: begin
                t = digits;
                if (t < 0) t = 0;
                if (t > int'(ACQ_MAX)) t = int'(ACQ_MAX);
                acq = t[9:0];
                r.load = 1'b1;
                r.reply = REPLY_K;
              end
              CMD_K: begin
                retries = '0;
                r.ack = 1'b1;
              end
              CMD_N: begin
                tally_failure(hit, p);
                r.resend = !hit;
                r.rst = p;
              end
              default: begin
                tally_failure(hit, p);
                r.rst = p;
                r.reply = REPLY_N;
              end
            endcase
          end
        end
        frame_pos = frame_pos + 3'd1;
      end
      default: ;
    endcase
    r.acq = acq;
  endtask

  task automatic send_word(input action_t a, input logic [7:0] raw,
                           input bit typed, input frame_result_t want);
    bit            got;
    frame_result_t r;
    int unsigned   gap;
    int unsigned   roll;
    in_valid <= 1'b1;
    in_action <= a;
    in_rx_byte <= raw;
    do @(posedge clk); while (in_stall);
    predict_word(a, raw, got, r);
    if (got)
      results_due.push_back(typed ? want : r);
    if (a != ACT_IGNORE)
      words_sent++;
    // mostly back to back, some short gaps, a few long ones, and forced back-to-back runs
    roll = $urandom_range(0, 99);
    if (tx_quiet > 0) begin
      tx_quiet--;
      gap = 0;
    end else if (roll < 3) begin
      tx_quiet = $urandom_range(20, 40);
      gap = 0;
    end else if (roll < 55) begin
      gap = 0;
    end else if (roll < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [31:0] body, input bit bad,
                            input bit typed, input frame_result_t want);
    logic [31:0] c;
    logic [63:0] bytes;
    c = seed_q;
    for (int i = 3; i >= 0; i--)
      c = crc_step(c, body[8*i +: 8]);
    c = c ^ CRC_INVERT ^ {31'd0, bad};
    bytes = {body, c};
    for (int i = 7; i >= 0; i--)
      send_word(ACT_BYTE, bytes[8*i +: 8] + DECODE_OFFSET, typed, want);
  endtask

  task automatic random_frame();
    logic [7:0]  cmd;
    int unsigned pick;
    // finish off a broken frame first so the next one lines up
    while (frame_pos != 3'd0)
      send_word(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    cmd = CMD_G;
      2, 3:    cmd = CMD_L;
      4, 5:    cmd = CMD_K;
      6, 7:    cmd = CMD_N;
      default: cmd = 8'($urandom_range(0, 255));
    endcase
    send_frame({cmd, digit_byte(), digit_byte(), digit_byte()}, $urandom_range(0, 9) == 0,
               1'b0, '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input logic [31:0] seed, input logic [7:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CRC_SEED;
    cfg_data <= seed;
    do @(posedge clk); while (!cfg_ready);
    seed_q = seed;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_data <= {24'd0, limit};
    do @(posedge clk); while (!cfg_ready);
    limit_q = limit;
    cfg_valid <= 1'b0;
  endtask

  task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // Result side: checks each result taken and drives random stall
  int unsigned rx_left = 0;
  int unsigned results_seen = 0;
  bit          squeezed = 1'b0;

  always @(posedge clk) begin
    frame_result_t want;
    int unsigned   roll;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected, command %0h", $time, out_command);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          note_field("crc_ok", 32'(want.crc_ok), 32'(out_crc_ok));
          note_field("command", 32'(want.command), 32'(out_command));
          note_field("reply", 32'(want.reply), 32'(out_reply));
          note_field("go_pulse", 32'(want.go), 32'(out_go_pulse));
          note_field("load_counter", 32'(want.load), 32'(out_load_counter));
          note_field("acq_time", 32'(want.acq), 32'(out_acq_time));
          note_field("ack_seen", 32'(want.ack), 32'(out_ack_seen));
          note_field("resend", 32'(want.resend), 32'(out_resend));
          note_field("reset_pulse", 32'(want.rst), 32'(out_reset_pulse));
        end
      end
      if (!squeezed && results_seen >= 60) begin
        // long hold-off so the block backs up and stalls its input
        squeezed = 1'b1;
        out_stall <= 1'b1;
        rx_left = 200;
      end else if (rx_left > 0) begin
        rx_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          out_stall <= 1'b0;
          rx_left = $urandom_range(0, 15);
        end else if (roll < 88) begin
          out_stall <= 1'b1;
          rx_left = $urandom_range(0, 2);
        end else if (roll < 96) begin
          out_stall <= 1'b0;
          rx_left = $urandom_range(20, 60);
        end else begin
          out_stall <= 1'b1;
          rx_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    logic [31:0] seeds[5];
    logic [7:0]  limits[5];
    int unsigned target;
    int unsigned sel;

    plan[0] = '{1'b0, ACT_ACK_TIMEOUT, 32'd0, 1'b0, 1'b1,
                outcome(1'b0, 8'd0, REPLY_NONE, 1'b0, 1'b0, 10'd0, 1'b0, 1'b1, 1'b0)};
    plan[1] = plan[0];
    // third failure reaches the default limit
    plan[2] = '{1'b0, ACT_ACK_TIMEOUT, 32'd0, 1'b0, 1'b1,
                outcome(1'b0, 8'd0, REPLY_NONE, 1'b0, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1)};
    // digits far above range clamp to the top
    plan[3] = '{1'b1, ACT_BYTE, {CMD_L, 24'hF2F2F2}, 1'b0, 1'b1,
                outcome(1'b1, CMD_L, REPLY_K, 1'b0, 1'b1, ACQ_MAX, 1'b0, 1'b0, 1'b0)};
    plan[4] = '{1'b1, ACT_BYTE, 32'hF3007F80, 1'b1, 1'b1,
                outcome(1'b0, 8'hF3, REPLY_N, 1'b0, 1'b0, ACQ_MAX, 1'b0, 1'b0, 1'b0)};
    plan[5] = '{1'b1, ACT_BYTE, {CMD_G, 24'h313233}, 1'b0, 1'b1,
                outcome(1'b1, CMD_G, REPLY_K, 1'b1, 1'b1, ACQ_MAX, 1'b0, 1'b0, 1'b0)};
    plan[6] = '{1'b0, ACT_RESET_TIMER, 32'h00000000, 1'b0, 1'b0, '0};
    plan[7] = '{1'b0, ACT_IGNORE, 32'hFF000000, 1'b0, 1'b0, '0};
    // digits below '0' clamp to zero
    plan[8] = '{1'b1, ACT_BYTE, {CMD_L, 24'h000000}, 1'b0, 1'b0, '0};

    seeds[0] = 32'h0;         limits[0] = 8'd1;
    seeds[1] = 32'hFFFFFFFF;  limits[1] = 8'd255;
    seeds[2] = $urandom;      limits[2] = 8'($urandom_range(1, 6));
    seeds[3] = $urandom;      limits[3] = 8'd2;
    seeds[4] = $urandom;      limits[4] = 8'($urandom_range(1, 255));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_frame)
        send_frame(plan[i].body, plan[i].bad_crc, plan[i].typed, plan[i].want);
      else
        send_word(plan[i].act, plan[i].body[31:24], plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_settings(seeds[ph], limits[ph]);
      target = words_sent + 105;
      while (words_sent < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 62)
          random_frame();
        else if (sel < 77)
          send_word(ACT_ACK_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0, '0);
        else if (sel < 83)
          send_word(ACT_RESET_TIMER, 8'($urandom_range(0, 255)), 1'b0, '0);
        else if (sel < 86)
          send_word(ACT_IGNORE, 8'($urandom_range(0, 255)), 1'b0, '0);
        else
          repeat ($urandom_range(1, 5)) send_word(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0)
      $display("PASS command_frame_receiver");
    else
      $display("FAIL command_frame_receiver");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL command_frame_receiver");
    $finish;
  end

endmodule
